@@ rtl/core/sctl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package sctl_pkg;

  // Access modes.
  localparam logic [1:0] MODE_CHECK = 2'd0;
  localparam logic [1:0] MODE_FILL  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  // Result targets.
  localparam logic [1:0] TGT_NONE = 2'd0;
  localparam logic [1:0] TGT_MAIN = 2'd1;
  localparam logic [1:0] TGT_FAT0 = 2'd2;
  localparam logic [1:0] TGT_FAT1 = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_SET_BITS  = 3'd0;
  localparam logic [2:0] REG_MAX_RUN   = 3'd1;
  localparam logic [2:0] REG_FAT_START = 3'd2;
  localparam logic [2:0] REG_FAT_LEN   = 3'd3;
  localparam logic [2:0] REG_FAT0_EN   = 3'd4;
  localparam logic [2:0] REG_FAT1_EN   = 3'd5;

  localparam int unsigned PADDR_W = 5;

  // LRU touch masks, one per way.
  localparam logic [3:0][5:0] LRU_SET_BITS  = {6'h0B, 6'h14, 6'h20, 6'h00};
  localparam logic [3:0][5:0] LRU_KEEP_BITS = {6'h3F, 6'h3E, 6'h39, 6'h07};

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] sector;
    logic [15:0] run_length;
  } in_req_t;

  typedef struct packed {
    logic        hit;
    logic [1:0]  target;
    logic [1:0]  way_used;
    logic [9:0]  slot_index;
    logic        move_data;
  } out_rsp_t;

  typedef struct packed {
    logic [3:0]  set_index_bits;
    logic [15:0] max_cached_run;
    logic [31:0] fat_start_sector;
    logic [31:0] fat_length_sectors;
    logic        fat0_slot_enable;
    logic        fat1_slot_enable;
  } cfg_t;

  // One tag row: all four ways of a set with their LRU order code.
  typedef struct packed {
    logic [5:0]       lru;
    logic [3:0]       vld;
    logic [3:0][31:0] tag;
  } row_t;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic div;
    logic modr;
    logic rd;
    logic eval;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_busy;
  } sts_t;

  function automatic logic [5:0] lru_touch(logic [5:0] code, logic [1:0] way);
    lru_touch = (code | LRU_SET_BITS[way]) & LRU_KEEP_BITS[way];
  endfunction

  function automatic logic [1:0] lru_victim(logic [5:0] c);
    if ((c & 6'h38) == 6'h38)      lru_victim = 2'd0;
    else if ((c & 6'h26) == 6'h06) lru_victim = 2'd1;
    else if ((c & 6'h15) == 6'h01) lru_victim = 2'd2;
    else if ((c & 6'h0B) == 6'h00) lru_victim = 2'd3;
    else                           lru_victim = 2'd0;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/sector_cache_tag_lru_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_stall_o  in_req_i  (mode, sector, run_length)
// out       output     out_valid_o/out_stall_i out_rsp_o (hit, target, way, slot, move)
// cfg       input      APB psel/penable       paddr, pwdata, prdata
//
// Each request passes from acceptance to the result register through set index by
// reciprocal multiply (quotient, then remainder), tag row read, evaluate and write back.
// After reset a clearing pass writes every tag row, with in_stall_o high.
// A result waiting under out_stall_i holds the next request in its evaluate cycle.
module sector_cache_tag_lru_controller #(
  parameter int unsigned MAX_SETS = 256
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  sctl_pkg::in_req_t                   in_req_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output sctl_pkg::out_rsp_t                  out_rsp_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [sctl_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  sctl_pkg::cfg_t cfg_q;
  sctl_pkg::cmd_t cmd;
  sctl_pkg::sts_t sts;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.set_index_bits     <= 4'd8;
      cfg_q.max_cached_run     <= 16'hFFFF;
      cfg_q.fat_start_sector   <= '0;
      cfg_q.fat_length_sectors <= '0;
      cfg_q.fat0_slot_enable   <= 1'b1;
      cfg_q.fat1_slot_enable   <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        sctl_pkg::REG_SET_BITS:  cfg_q.set_index_bits     <= pwdata[3:0];
        sctl_pkg::REG_MAX_RUN:   cfg_q.max_cached_run     <= pwdata[15:0];
        sctl_pkg::REG_FAT_START: cfg_q.fat_start_sector   <= pwdata;
        sctl_pkg::REG_FAT_LEN:   cfg_q.fat_length_sectors <= pwdata;
        sctl_pkg::REG_FAT0_EN:   cfg_q.fat0_slot_enable   <= pwdata[0];
        sctl_pkg::REG_FAT1_EN:   cfg_q.fat1_slot_enable   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (reg_idx)
      sctl_pkg::REG_SET_BITS:  prdata = {28'd0, cfg_q.set_index_bits};
      sctl_pkg::REG_MAX_RUN:   prdata = {16'd0, cfg_q.max_cached_run};
      sctl_pkg::REG_FAT_START: prdata = cfg_q.fat_start_sector;
      sctl_pkg::REG_FAT_LEN:   prdata = cfg_q.fat_length_sectors;
      sctl_pkg::REG_FAT0_EN:   prdata = {31'd0, cfg_q.fat0_slot_enable};
      sctl_pkg::REG_FAT1_EN:   prdata = {31'd0, cfg_q.fat1_slot_enable};
      default:                 prdata = '0;
    endcase
  end

  sctl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sctl_dpath #(
    .MAX_SETS (MAX_SETS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
`default_nettype wire

@@ rtl/core/sctl_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sctl_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  sctl_pkg::sts_t     sts_i,
  output sctl_pkg::cmd_t     cmd_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_MOD   = 3'd3;
  localparam logic [2:0] ST_RD    = 3'd4;
  localparam logic [2:0] ST_EVAL  = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  // Sequencing: clearing pass after reset, then per request set index, tag row read, evaluate and write back.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = ST_MOD;
      end
      ST_MOD: begin
        cmd_o.modr = 1'b1;
        state_d    = ST_RD;
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_EVAL;
      end
      ST_EVAL: begin
        if (!sts_i.out_busy) begin
          cmd_o.eval = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/sctl_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sctl_dpath #(
  parameter int unsigned MAX_SETS = 256
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  sctl_pkg::cfg_t      cfg_i,
  input  sctl_pkg::in_req_t   in_req_i,
  input  sctl_pkg::cmd_t      cmd_i,
  output sctl_pkg::sts_t      sts_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output sctl_pkg::out_rsp_t  out_rsp_o
);

  localparam int unsigned SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam logic [63:0] RECIP_W =
      ((64'd1 << 32) + 64'(MAX_SETS) - 64'd1) / 64'(MAX_SETS);
  localparam logic [32:0] RECIP = RECIP_W[32:0];
  localparam logic [12:0] DIVISOR = 13'(MAX_SETS);
  localparam logic [SET_W-1:0] LAST_SET = SET_W'(MAX_SETS - 1);

  sctl_pkg::in_req_t  req_q;
  sctl_pkg::row_t     mem [MAX_SETS];
  sctl_pkg::row_t     row_q, row_new;
  sctl_pkg::out_rsp_t rsp_q, rsp_d;
  logic [SET_W-1:0]   clr_q, set_q;
  logic [14:0]        low_q, quot_q, mask;
  logic [47:0]        quot_prod;
  logic [27:0]        rem_prod;
  logic [14:0]        rem;
  logic               out_valid_q;
  logic [31:0]        fat0_tag_q, fat1_tag_q, fat0_tag_d, fat1_tag_d;
  logic               fat0_vld_q, fat1_vld_q, fat0_vld_d, fat1_vld_d;

  // Masked set bits, then modulo the set count by reciprocal multiply.
  assign mask      = 15'((16'd1 << cfg_i.set_index_bits) - 16'd1);
  assign quot_prod = 48'(low_q) * 48'(RECIP);
  assign rem_prod  = 28'(quot_q) * 28'(DIVISOR);
  assign rem       = low_q - rem_prod[14:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_req_i;
      low_q <= in_req_i.sector[14:0] & mask;
    end
    if (cmd_i.div) quot_q <= quot_prod[46:32];
    if (cmd_i.modr) set_q <= rem[SET_W-1:0];
  end

  // Tag row memory; rows are zeroed by the clearing pass after reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      mem[clr_q] <= '0;
    end else if (cmd_i.eval) begin
      mem[set_q] <= row_new;
    end
    if (cmd_i.rd) row_q <= mem[set_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_q <= clr_q + SET_W'(1);
    end
  end

  assign sts_o.clr_last = (clr_q == LAST_SET);
  assign sts_o.out_busy = out_valid_q && out_stall_i;

  // Lookup, replacement and result for the current request.
  always_comb begin
    logic [3:0]  way_hit;
    logic        any_hit, long_run, is_write;
    logic [1:0]  hway, way;
    logic [31:0] fat1_pos;
    logic [17:0] cache_size;
    logic [SET_W+11:0] slot_full;
    way_hit = '0;
    for (int w = 0; w < 4; w++) begin
      way_hit[w] = row_q.vld[w] && (row_q.tag[w] == req_q.sector);
    end
    any_hit  = |way_hit;
    hway     = way_hit[0] ? 2'd0 : way_hit[1] ? 2'd1 : way_hit[2] ? 2'd2 : 2'd3;
    long_run = req_q.run_length > cfg_i.max_cached_run;
    is_write = (req_q.mode == sctl_pkg::MODE_WRITE);
    fat1_pos = cfg_i.fat_start_sector + cfg_i.fat_length_sectors;
    cache_size = 18'd4 << cfg_i.set_index_bits;
    way        = 2'd0;
    row_new    = row_q;
    fat0_tag_d = fat0_tag_q;
    fat0_vld_d = fat0_vld_q;
    fat1_tag_d = fat1_tag_q;
    fat1_vld_d = fat1_vld_q;
    rsp_d      = '0;
    if (req_q.mode == sctl_pkg::MODE_CHECK || req_q.mode == sctl_pkg::MODE_READ) begin
      if (req_q.mode == sctl_pkg::MODE_CHECK && {2'b00, req_q.run_length} > cache_size) begin
        rsp_d = '0;
      end else if (cfg_i.fat0_slot_enable && fat0_vld_q && fat0_tag_q == req_q.sector) begin
        rsp_d.hit       = 1'b1;
        rsp_d.target    = sctl_pkg::TGT_FAT0;
        rsp_d.move_data = (req_q.mode == sctl_pkg::MODE_READ);
      end else if (cfg_i.fat1_slot_enable && fat1_vld_q && fat1_tag_q == req_q.sector) begin
        rsp_d.hit       = 1'b1;
        rsp_d.target    = sctl_pkg::TGT_FAT1;
        rsp_d.move_data = (req_q.mode == sctl_pkg::MODE_READ);
      end else if (any_hit) begin
        rsp_d.hit    = 1'b1;
        rsp_d.target = sctl_pkg::TGT_MAIN;
        way          = hway;
        if (req_q.mode == sctl_pkg::MODE_READ) begin
          rsp_d.move_data = 1'b1;
          row_new.lru     = sctl_pkg::lru_touch(row_q.lru, hway);
        end
      end
    end else if (!(req_q.mode == sctl_pkg::MODE_FILL && long_run)) begin
      if (cfg_i.fat0_slot_enable && req_q.sector == cfg_i.fat_start_sector) begin
        rsp_d.target = sctl_pkg::TGT_FAT0;
        rsp_d.hit    = fat0_vld_q && (fat0_tag_q == req_q.sector);
        if (is_write || !rsp_d.hit) begin
          fat0_tag_d      = req_q.sector;
          fat0_vld_d      = 1'b1;
          rsp_d.move_data = 1'b1;
        end
      end else if (cfg_i.fat1_slot_enable && req_q.sector == fat1_pos) begin
        rsp_d.target = sctl_pkg::TGT_FAT1;
        rsp_d.hit    = fat1_vld_q && (fat1_tag_q == req_q.sector);
        if (is_write || !rsp_d.hit) begin
          fat1_tag_d      = req_q.sector;
          fat1_vld_d      = 1'b1;
          rsp_d.move_data = 1'b1;
        end
      end else if (any_hit) begin
        rsp_d.hit       = 1'b1;
        rsp_d.target    = sctl_pkg::TGT_MAIN;
        way             = hway;
        rsp_d.move_data = is_write;
        if (!(is_write && long_run)) row_new.lru = sctl_pkg::lru_touch(row_q.lru, hway);
      end else if (!(is_write && long_run)) begin
        rsp_d.target         = sctl_pkg::TGT_MAIN;
        way                  = sctl_pkg::lru_victim(row_q.lru);
        row_new.tag[way]     = req_q.sector;
        row_new.vld[way]     = 1'b1;
        row_new.lru          = sctl_pkg::lru_touch(row_q.lru, way);
        rsp_d.move_data      = 1'b1;
      end
    end
    slot_full = {10'd0, set_q, way};
    if (rsp_d.target == sctl_pkg::TGT_MAIN) begin
      rsp_d.way_used   = way;
      rsp_d.slot_index = slot_full[9:0];
    end
  end

  // FAT slot tags and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fat0_vld_q  <= 1'b0;
      fat1_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.eval || (out_valid_q && out_stall_i);
      if (cmd_i.eval) begin
        fat0_vld_q <= fat0_vld_d;
        fat1_vld_q <= fat1_vld_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      fat0_tag_q <= fat0_tag_d;
      fat1_tag_q <= fat1_tag_d;
      rsp_q      <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule
`default_nettype wire
